@@ rtl/point_in_polygon_test_defines.svh @@
// assertion macros for the checker file of point_in_polygon_test
// expects aclk and aresetn in the scope where a macro is used
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// checked while out of reset
`define PIP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define PIP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/pip_pkg.sv @@
// shared types and constants of the point-in-polygon test block
// no dependencies
package pip_pkg;

    localparam int NUM_VERTICES = 10;
    localparam int COORD_WIDTH  = 16;
    localparam int IDX_WIDTH    = 4;
    localparam int CNT_WIDTH    = 4;
    localparam int VADDR_WIDTH  = $clog2(NUM_VERTICES);
    localparam int WALK_WIDTH   = $clog2(NUM_VERTICES + 1);
    localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
    localparam int PROD_WIDTH   = 2 * DIFF_WIDTH;
    localparam int CMP_WIDTH    = PROD_WIDTH + 1;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                          cmd;
        logic [IDX_WIDTH-1:0]          vertex_index;
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
    } pip_in_t;

    typedef struct packed {
        logic                 inside_res;
        logic [CNT_WIDTH-1:0] crossings;
    } pip_out_t;

    typedef enum logic {
        OP_WRITE,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t                           op;
        logic [VADDR_WIDTH-1:0]        addr;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } work_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_DRAIN,
        BK_DONE
    } back_state_t;

endpackage

@@ rtl/pip_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pip_front.sv @@
// front end: decodes input items into work for the queue, drops bad writes
// depends on pip_pkg
module pip_front (
    input  logic             s_valid,
    output logic             s_ready,
    input  pip_pkg::pip_in_t s_data,
    output logic             push_valid,
    input  logic             push_ready,
    output pip_pkg::work_t   push_item
);
    import pip_pkg::*;

    logic is_query;
    logic idx_ok;

    assign is_query = (s_data.cmd == CMD_QUERY);
    assign idx_ok   = (32'(s_data.vertex_index) < NUM_VERTICES);

    // out-of-range writes are taken and discarded
    assign s_ready    = push_ready;
    assign push_valid = s_valid && (is_query || idx_ok);

    always_comb begin
        push_item.op   = is_query ? OP_QUERY : OP_WRITE;
        push_item.addr = VADDR_WIDTH'(s_data.vertex_index);
        push_item.x    = s_data.coord_x;
        push_item.y    = s_data.coord_y;
    end

endmodule

@@ rtl/pip_queue.sv @@
// short work queue between front and back end
// depends on pip_pkg
module pip_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  pip_pkg::work_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output pip_pkg::work_t pop_item
);
    import pip_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    work_t             entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != (PW + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    // depth is a power of two, pointers wrap naturally
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/pip_back.sv @@
// back end: vertex table writes and the edge-walk crossing counter
// depends on pip_pkg and pip_ram
module pip_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  pip_pkg::work_t    q_item,
    output logic              m_valid,
    input  logic              m_ready,
    output pip_pkg::pip_out_t m_data
);
    import pip_pkg::*;

    back_state_t state_reg, state_next;

    logic [WALK_WIDTH-1:0]  rd_cnt_reg, rd_cnt_next;
    logic                   ram_we, ram_re;
    logic [VADDR_WIDTH-1:0] ram_raddr;
    logic [2*COORD_WIDTH-1:0] ram_wdata, ram_rdata;
    logic                   start, load_out;

    logic signed [COORD_WIDTH-1:0] px_reg, py_reg;
    logic signed [COORD_WIDTH-1:0] vi_x, vi_y;
    logic signed [COORD_WIDTH-1:0] vj_x_reg, vj_y_reg;

    logic r0_vld_reg, r0_edge_reg, r0_last_reg;

    logic                         s1_vld_reg, s1_last_reg, s1_span_reg, s1_dpos_reg;
    logic signed [DIFF_WIDTH-1:0] s1_dx_reg, s1_d_reg, s1_ex_reg, s1_dy_reg;

    logic                         s2_vld_reg, s2_last_reg, s2_span_reg, s2_dpos_reg;
    logic signed [PROD_WIDTH-1:0] s2_p1_reg, s2_p2_reg;

    logic signed [CMP_WIDTH-1:0]  diff;
    logic                         hit;
    logic [WALK_WIDTH-1:0]        cnt_reg, cnt_next;

    logic     m_valid_reg;
    pip_out_t m_data_reg;

    // vertex table, x in the upper half
    pip_ram #(
        .WIDTH (2 * COORD_WIDTH),
        .DEPTH (NUM_VERTICES)
    ) u_vtx_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (q_item.addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_wdata = {q_item.x, q_item.y};
    assign vi_x      = ram_rdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign vi_y      = ram_rdata[COORD_WIDTH-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid && q_item.op == OP_QUERY) begin
                    state_next = BK_WALK;
                end
            end
            BK_WALK: begin
                if (rd_cnt_reg == WALK_WIDTH'(NUM_VERTICES)) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (s2_vld_reg && s2_last_reg) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        q_ready     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        start       = 1'b0;
        load_out    = 1'b0;
        rd_cnt_next = rd_cnt_reg;
        ram_raddr   = VADDR_WIDTH'(NUM_VERTICES - 1);
        case (state_reg)
            BK_IDLE: begin
                q_ready     = 1'b1;
                ram_we      = q_valid && q_item.op == OP_WRITE;
                start       = q_valid && q_item.op == OP_QUERY;
                rd_cnt_next = '0;
            end
            BK_WALK: begin
                // first read fetches the last vertex, then 0 upward
                ram_re      = 1'b1;
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg != '0) begin
                    ram_raddr = VADDR_WIDTH'(rd_cnt_reg - 1'b1);
                end
            end
            BK_DRAIN: begin
                rd_cnt_next = rd_cnt_reg;
            end
            BK_DONE: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
                q_ready = 1'b0;
            end
        endcase
    end

    // final compare: sign of p1 - p2 against sign of the edge's dy
    assign diff = {s2_p1_reg[PROD_WIDTH-1], s2_p1_reg} - {s2_p2_reg[PROD_WIDTH-1], s2_p2_reg};
    assign hit  = s2_vld_reg && s2_span_reg &&
                  (s2_dpos_reg ? (!diff[CMP_WIDTH-1] && diff != '0) : diff[CMP_WIDTH-1]);

    always_comb begin
        cnt_next = cnt_reg;
        if (start) begin
            cnt_next = '0;
        end else if (hit) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            rd_cnt_reg  <= '0;
            r0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            r0_vld_reg <= ram_re;
            s1_vld_reg <= r0_vld_reg && r0_edge_reg;
            s2_vld_reg <= s1_vld_reg;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        r0_edge_reg <= (rd_cnt_reg != '0);
        r0_last_reg <= (rd_cnt_reg == WALK_WIDTH'(NUM_VERTICES));
        if (start) begin
            px_reg <= q_item.x;
            py_reg <= q_item.y;
        end
        if (r0_vld_reg) begin
            vj_x_reg <= vi_x;
            vj_y_reg <= vi_y;
        end
        // edge from vertex j (previous) to vertex i (current)
        s1_last_reg <= r0_last_reg;
        s1_span_reg <= (vi_y <= py_reg && py_reg < vj_y_reg) ||
                       (vj_y_reg <= py_reg && py_reg < vi_y);
        s1_dpos_reg <= (vj_y_reg > vi_y);
        s1_dx_reg   <= {px_reg[COORD_WIDTH-1], px_reg} - {vi_x[COORD_WIDTH-1], vi_x};
        s1_d_reg    <= {vj_y_reg[COORD_WIDTH-1], vj_y_reg} - {vi_y[COORD_WIDTH-1], vi_y};
        s1_ex_reg   <= {vj_x_reg[COORD_WIDTH-1], vj_x_reg} - {vi_x[COORD_WIDTH-1], vi_x};
        s1_dy_reg   <= {py_reg[COORD_WIDTH-1], py_reg} - {vi_y[COORD_WIDTH-1], vi_y};
        s2_last_reg <= s1_last_reg;
        s2_span_reg <= s1_span_reg;
        s2_dpos_reg <= s1_dpos_reg;
        s2_p1_reg   <= s1_dx_reg * s1_d_reg;
        s2_p2_reg   <= s1_ex_reg * s1_dy_reg;
        if (load_out) begin
            m_data_reg.inside_res <= cnt_reg[0];
            m_data_reg.crossings  <= CNT_WIDTH'(cnt_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/point_in_polygon_test.sv @@
// top level of the point-in-polygon test block
// depends on pip_pkg, pip_front, pip_queue, pip_back, pip_ram
//
// usage
//   s_ channel: one item per handshake. cmd write stores vertex_index/coord_x/
//   coord_y in the vertex table (slots at or beyond the table size are dropped
//   without a result). cmd query tests the point coord_x/coord_y.
//   m_ channel: one item per query, inside_res (crossing parity) and crossings.
// timing
//   the back end handles one query at a time and takes no new item until the
//   result is loaded into the output register. the single read port of the
//   vertex ram walks NUM_VERTICES + 1 entries, one per cycle, followed by a
//   three-stage edge pipeline (differences, products, compare). vertex writes
//   retire one per cycle while the back end is idle.
// flow control
//   a two-entry queue sits between the front end and the back end, and the
//   result sits in an output register, so input items keep being taken while
//   a result waits. a stalled receiver only stops the back end at the end of
//   the next query; the queue then fills and s_ready drops.
// reset
//   aresetn is synchronous, active low; it empties the queue and the output.
//   the vertex table is not cleared and must be written before a query.
module point_in_polygon_test (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pip_pkg::pip_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pip_pkg::pip_out_t m_data
);
    import pip_pkg::*;

    // front end to queue
    logic  push_valid;
    logic  push_ready;
    work_t push_item;

    // queue to back end
    logic  pop_valid;
    logic  pop_ready;
    work_t pop_item;

    // decode and filter incoming items
    pip_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // decouples acceptance from the edge walk
    pip_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // vertex table, edge walk and result register
    pip_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_item  (pop_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ rtl/pip_checker.sv @@
// port-level checks for the point-in-polygon test block, bound to the top
// depends on pip_pkg and point_in_polygon_test_defines.svh
`include "point_in_polygon_test_defines.svh"

module pip_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input pip_pkg::pip_out_t m_data
);
    import pip_pkg::*;

    `PIP_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")
    `PIP_ASSERT(a_parity, m_valid |-> m_data.inside_res == m_data.crossings[0], "inside flag is not the crossing parity")
    `PIP_ASSERT(a_count_range, m_valid |-> m_data.crossings <= CNT_WIDTH'(NUM_VERTICES), "more crossings than edges")
    `PIP_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);
